@@ design/ciau_pkg.sv @@
// Shared types and constants for the overflow-checked integer ALU.
`default_nettype none

package ciau_pkg;

  // Operation code, taken from bits 3..2 of the command.
  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } op_e;

  // Operand type, taken from bits 1..0 of the command.
  typedef enum logic [1:0] {
    TY_U32 = 2'd0,
    TY_I32 = 2'd1,
    TY_U64 = 2'd2,
    TY_I64 = 2'd3
  } type_e;

  // Status reported with each result.
  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_OVF  = 2'd1,
    ST_DIVZ = 2'd2
  } status_e;

  localparam int unsigned DivSteps = 64;

  // Control fields that travel with an item down the pipeline.
  typedef struct packed {
    op_e   op;
    type_e typ;
    logic  neg;
    logic  divz;
    logic  minovf;
  } ctl_t;

  // Payload of one divider stage.
  typedef struct packed {
    ctl_t        ctl;
    logic [63:0] rem;
    logic [63:0] quo;
    logic [63:0] dvs;
    logic [63:0] res;
    status_e     st;
  } dstage_t;

endpackage

`default_nettype wire

@@ design/checked_integer_alu_unit.sv @@
// Top level of the overflow-checked integer ALU: decode, add/subtract, multiply and divide pipeline.
//
//  Channel | Valid        | Stall        | Fields
//  --------+--------------+--------------+---------------------------------------
//  input   | in_valid_i   | in_stall_o   | cmd_i, operand_a_i, operand_b_i
//  output  | out_valid_o  | out_stall_i  | result_value_o, status_o
//
// Every item passes through four front stages (input, decoded operands, sum and
// partial products, product), the 64-stage restoring divider that all
// operations pass through, and the output register. One item may enter in
// every cycle unless in_stall_o is high. The whole pipeline holds while
// a result waits at the output and out_stall_i is high. Reset clears only the
// valid bits.
`default_nettype none

module checked_integer_alu_unit (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [3:0]  cmd_i,
  input  wire logic [63:0] operand_a_i,
  input  wire logic [63:0] operand_b_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [63:0]      result_value_o,
  output logic [1:0]       status_o
);
  import ciau_pkg::*;

  logic adv;

  // Pipeline advances unless a finished item is held at the output.
  assign adv        = !(out_valid_o && out_stall_i);
  assign in_stall_o = !adv;

  // Stage 1: input registers.
  logic        v1_q;
  logic [3:0]  cmd1_q;
  logic [63:0] a1_q, b1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (adv) begin
      v1_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      cmd1_q <= cmd_i;
      a1_q   <= operand_a_i;
      b1_q   <= operand_b_i;
    end
  end

  // Decode: extend operands to 65 bits, take magnitudes and flag special cases.
  ctl_t        ctl1;
  logic [64:0] ea1, eb1;
  logic [63:0] ma1, mb1;

  always_comb begin
    ctl1.op  = op_e'(cmd1_q[3:2]);
    ctl1.typ = type_e'(cmd1_q[1:0]);
    case (ctl1.typ)
      TY_U32: begin
        ea1 = {33'd0, a1_q[31:0]};
        eb1 = {33'd0, b1_q[31:0]};
      end
      TY_I32: begin
        ea1 = {{33{a1_q[31]}}, a1_q[31:0]};
        eb1 = {{33{b1_q[31]}}, b1_q[31:0]};
      end
      TY_U64: begin
        ea1 = {1'b0, a1_q};
        eb1 = {1'b0, b1_q};
      end
      default: begin
        ea1 = {a1_q[63], a1_q};
        eb1 = {b1_q[63], b1_q};
      end
    endcase
    ma1 = ea1[64] ? -ea1[63:0] : ea1[63:0];
    mb1 = eb1[64] ? -eb1[63:0] : eb1[63:0];
    ctl1.neg  = ea1[64] ^ eb1[64];
    ctl1.divz = (eb1 == 65'd0);
    case (ctl1.typ)
      TY_I32:  ctl1.minovf = (a1_q[31:0] == 32'h8000_0000) && (b1_q[31:0] == 32'hFFFF_FFFF);
      TY_I64:  ctl1.minovf = (a1_q == 64'h8000_0000_0000_0000) && (b1_q == '1);
      default: ctl1.minovf = 1'b0;
    endcase
  end

  // Stage 2: decoded operands.
  logic        v2_q;
  ctl_t        ctl2_q;
  logic [64:0] ea2_q, eb2_q;
  logic [63:0] ma2_q, mb2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (adv) begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      ctl2_q <= ctl1;
      ea2_q  <= ea1;
      eb2_q  <= eb1;
      ma2_q  <= ma1;
      mb2_q  <= mb1;
    end
  end

  // Add or subtract exactly, and form the four 32x32 partial products.
  logic [65:0] sum2;
  logic [63:0] pp00_2, pp01_2, pp10_2, pp11_2;

  always_comb begin
    if (ctl2_q.op == OP_SUB) begin
      sum2 = {ea2_q[64], ea2_q} - {eb2_q[64], eb2_q};
    end else begin
      sum2 = {ea2_q[64], ea2_q} + {eb2_q[64], eb2_q};
    end
    pp00_2 = {32'd0, ma2_q[31:0]}  * {32'd0, mb2_q[31:0]};
    pp01_2 = {32'd0, ma2_q[31:0]}  * {32'd0, mb2_q[63:32]};
    pp10_2 = {32'd0, ma2_q[63:32]} * {32'd0, mb2_q[31:0]};
    pp11_2 = {32'd0, ma2_q[63:32]} * {32'd0, mb2_q[63:32]};
  end

  // Stage 3: sum and partial products.
  logic        v3_q;
  ctl_t        ctl3_q;
  logic [65:0] sum3_q;
  logic [63:0] pp00_3_q, pp01_3_q, pp10_3_q, pp11_3_q;
  logic [63:0] ma3_q, mb3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else if (adv) begin
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      ctl3_q   <= ctl2_q;
      sum3_q   <= sum2;
      pp00_3_q <= pp00_2;
      pp01_3_q <= pp01_2;
      pp10_3_q <= pp10_2;
      pp11_3_q <= pp11_2;
      ma3_q    <= ma2_q;
      mb3_q    <= mb2_q;
    end
  end

  // Full 128-bit magnitude product.
  logic [127:0] prod3;

  assign prod3 = {64'd0, pp00_3_q} + {32'd0, pp01_3_q, 32'd0}
               + {32'd0, pp10_3_q, 32'd0} + {pp11_3_q, 64'd0};

  // Stage 4: product and sum.
  logic         v4_q;
  ctl_t         ctl4_q;
  logic [65:0]  sum4_q;
  logic [127:0] prod4_q;
  logic [63:0]  ma4_q, mb4_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q <= 1'b0;
    end else if (adv) begin
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      ctl4_q  <= ctl3_q;
      sum4_q  <= sum3_q;
      prod4_q <= prod3;
      ma4_q   <= ma3_q;
      mb4_q   <= mb3_q;
    end
  end

  // Range checks and wrapped values for add, subtract and multiply.
  logic        is32_4, ovf4;
  logic [63:0] val4, pneg4;

  always_comb begin
    is32_4 = (ctl4_q.typ == TY_U32) || (ctl4_q.typ == TY_I32);
    pneg4  = ctl4_q.neg ? -prod4_q[63:0] : prod4_q[63:0];
    if (ctl4_q.op == OP_MUL) begin
      val4 = pneg4;
      case (ctl4_q.typ)
        TY_U32:  ovf4 = (prod4_q[127:32] != '0);
        TY_I32:  ovf4 = !((prod4_q[127:31] == '0) ||
                          (ctl4_q.neg && (prod4_q == 128'h8000_0000)));
        TY_U64:  ovf4 = (prod4_q[127:64] != '0);
        default: ovf4 = !((prod4_q[127:63] == '0) ||
                          (ctl4_q.neg && (prod4_q == {64'd0, 64'h8000_0000_0000_0000})));
      endcase
    end else begin
      val4 = sum4_q[63:0];
      case (ctl4_q.typ)
        TY_U32:  ovf4 = (sum4_q[65:32] != '0);
        TY_I32:  ovf4 = !((sum4_q[65:31] == '0) || (sum4_q[65:31] == '1));
        TY_U64:  ovf4 = (sum4_q[65:64] != '0);
        default: ovf4 = !((sum4_q[65:63] == '0) || (sum4_q[65:63] == '1));
      endcase
    end
    if (is32_4) begin
      val4 = {32'd0, val4[31:0]};
    end
  end

  // Restoring divider, one quotient bit per stage.
  logic    dv_q [0:DivSteps];
  dstage_t dd_q [0:DivSteps];
  dstage_t d0;

  // Shift in the next dividend bit and subtract the divisor where it fits.
  function automatic dstage_t div_step(dstage_t s);
    logic [64:0] trial;
    logic [65:0] diff;
    dstage_t     n;
    trial = {s.rem, s.quo[63]};
    diff  = {1'b0, trial} - {2'b00, s.dvs};
    n     = s;
    if (!diff[65]) begin
      n.rem = diff[63:0];
      n.quo = {s.quo[62:0], 1'b1};
    end else begin
      n.rem = trial[63:0];
      n.quo = {s.quo[62:0], 1'b0};
    end
    return n;
  endfunction

  always_comb begin
    d0.ctl = ctl4_q;
    d0.rem = '0;
    d0.quo = ma4_q;
    d0.dvs = mb4_q;
    d0.res = val4;
    d0.st  = ovf4 ? ST_OVF : ST_OK;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int unsigned k = 0; k <= DivSteps; k++) begin
        dv_q[k] <= 1'b0;
      end
    end else if (adv) begin
      dv_q[0] <= v4_q;
      for (int unsigned k = 0; k < DivSteps; k++) begin
        dv_q[k+1] <= dv_q[k];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      dd_q[0] <= d0;
      for (int unsigned k = 0; k < DivSteps; k++) begin
        dd_q[k+1] <= div_step(dd_q[k]);
      end
    end
  end

  // Final selection: quotient sign and division special cases.
  dstage_t     dl;
  logic        is32_l;
  logic [63:0] qs_l;
  logic [63:0] res_d;
  status_e     st_d;

  always_comb begin
    dl     = dd_q[DivSteps];
    is32_l = (dl.ctl.typ == TY_U32) || (dl.ctl.typ == TY_I32);
    qs_l   = dl.ctl.neg ? -dl.quo : dl.quo;
    if (is32_l) begin
      qs_l = {32'd0, qs_l[31:0]};
    end
    res_d = dl.res;
    st_d  = dl.st;
    if (dl.ctl.op == OP_DIV) begin
      if (dl.ctl.divz) begin
        res_d = '0;
        st_d  = ST_DIVZ;
      end else if (dl.ctl.minovf) begin
        res_d = '0;
        st_d  = ST_OVF;
      end else begin
        res_d = qs_l;
        st_d  = ST_OK;
      end
    end
  end

  // Output register.
  logic        out_valid_q;
  logic [63:0] res_q;
  status_e     st_q;
  logic        is32_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= dv_q[DivSteps];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      res_q  <= res_d;
      st_q   <= st_d;
      is32_q <= is32_l;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign result_value_o = res_q;
  assign status_o       = st_q;

  // The unused status code never appears.
  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (status_o != 2'b11))
    else $error("status code three produced");

  // A 32-bit result has its upper half cleared.
  a_upper_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && is32_q) |-> (result_value_o[63:32] == 32'd0))
    else $error("32-bit result has upper bits set");

  // Division by zero always gives a zero value.
  a_divz_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (status_o == ST_DIVZ)) |-> (result_value_o == 64'd0))
    else $error("division by zero gave nonzero value");

endmodule

`default_nettype wire
